@@ rtl/sia_pkg.sv @@
// ============================================================================
// sia_pkg: sequence identity average shared definitions
// Field widths and fixed constants used by the channel interfaces and core.
// ============================================================================
package sia_pkg;

   localparam int BASE_W = 8;
   localparam int THR_W  = 7;
   localparam int ID_W   = 15;

   // 100 percent in Q8
   localparam logic [ID_W-1:0]  FULL_SCORE_Q8 = 15'd25600;
   localparam logic [THR_W-1:0] THR_RESET     = 7'd70;

   typedef logic [BASE_W-1:0] base_type;
   typedef logic [ID_W-1:0]   identity_type;
   typedef logic [THR_W-1:0]  threshold_type;

endpackage

@@ rtl/sia_req_if.sv @@
// ============================================================================
// sia_req_if: position request channel
// Valid/ready channel carrying one aligned position of the two sequence sets.
// ============================================================================
interface sia_req_if;
   import sia_pkg::*;

   logic     valid;
   logic     ready;
   base_type base_first;
   logic     first_present;
   base_type base_second;
   logic     second_present;
   logic     end_of_sequence;
   logic     end_of_set;

   modport source (
      output valid, base_first, first_present, base_second, second_present,
             end_of_sequence, end_of_set,
      input  ready
   );

   modport sink (
      input  valid, base_first, first_present, base_second, second_present,
             end_of_sequence, end_of_set,
      output ready
   );

endinterface

@@ rtl/sia_rsp_if.sv @@
// ============================================================================
// sia_rsp_if: set result channel
// Valid/ready channel carrying the average identity and same-kind flag.
// ============================================================================
interface sia_rsp_if;
   import sia_pkg::*;

   logic         valid;
   logic         ready;
   identity_type identity_q8;
   logic         same_kind;

   modport source (
      output valid, identity_q8, same_kind,
      input  ready
   );

   modport sink (
      input  valid, identity_q8, same_kind,
      output ready
   );

endinterface

@@ rtl/sequence_identity_average_core.sv @@
// ============================================================================
// sequence_identity_average_core: average percent identity of two sequence sets
// Counts mismatches per aligned pair, scores each pair in Q8 percent with a
// shared restoring divider, and reports the set average with a same-kind flag.
// ============================================================================
// Usage:
//   req_ch carries one aligned position per request. end_of_sequence closes a
//   pair, end_of_set closes the pair and the set. rsp_ch returns one result per
//   set: identity_q8 (average percent * 256) and same_kind (average reaches
//   the csr threshold, written through csr_we/csr_wdata).
// Flow:
//   A plain position is accepted while idle. Closing a non-empty pair runs
//   the constant multiply and then the shared divider, whose width DIV_W is
//   the wider of the pair numerator and the score total (32 bits with the
//   default parameters). Closing a set adds a setup step and, if the set
//   holds pairs, a second divider pass for the average; the result is then
//   held in the output register. req_ch.ready is high only while the block
//   is idle, so no request is taken while a close is worked or a result is
//   pending. The user must write the threshold only while idle; csr_we is
//   not gated by state in the block.
// Reset:
//   Synchronous reset clears all counters, the output valid and sets the
//   threshold to 70. If the receiver stalls the result holds in its register
//   and no new request is taken until it is taken.
// ============================================================================
module sequence_identity_average_core #(
   parameter int MAX_SEQ_LEN = 65536,
   parameter int MAX_PAIRS   = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   sia_req_if.sink                req_ch,
   sia_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  sia_pkg::threshold_type csr_wdata
);
   import sia_pkg::*;

   localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);
   localparam int PC_W  = $clog2(MAX_PAIRS + 1);
   localparam int SUM_W = $clog2(MAX_PAIRS * 25600 + 1);
   localparam int NUM_W = LEN_W + ID_W;
   localparam int DEN_W = (LEN_W > PC_W) ? LEN_W : PC_W;
   localparam int DIV_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int CNT_W = $clog2(DIV_W);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MUL     = 3'd1;
   localparam logic [2:0] ST_DIVPAIR = 3'd2;
   localparam logic [2:0] ST_SETUP   = 3'd3;
   localparam logic [2:0] ST_DIVAVG  = 3'd4;
   localparam logic [2:0] ST_OUT     = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] mis_ff, mis_in;
   logic [SUM_W-1:0] total_ff, total_in;
   logic [PC_W-1:0]  pairs_ff, pairs_in;
   threshold_type    thr_ff, thr_in;
   logic             set_ff, set_in;
   logic             valid_ff, valid_in;
   logic [LEN_W-1:0] diff_ff, diff_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   identity_type     res_ff, res_in;
   logic             kind_ff, kind_in;

   logic [LEN_W-1:0] pos_upd, mis_upd;
   logic [DEN_W:0]   rem_shift, rem_sub;
   logic             q_bit;
   logic [DIV_W-1:0] num_step;
   logic             div_done;
   identity_type     quot;
   identity_type     thr_q8;
   logic             close_pair;
   logic             room;

   assign thr_q8 = {thr_ff, 8'd0};

   // position bookkeeping for the incoming request
   always_comb begin
      pos_upd = pos_ff;
      mis_upd = mis_ff;
      if ((req_ch.first_present || req_ch.second_present) &&
          (pos_ff < LEN_W'(MAX_SEQ_LEN))) begin
         pos_upd = pos_ff + LEN_W'(1);
         if (!(req_ch.first_present && req_ch.second_present) ||
             (req_ch.base_first != req_ch.base_second))
            mis_upd = mis_ff + LEN_W'(1);
      end
   end

   // one restoring divider step, shared by pair scores and the set average
   always_comb begin
      rem_shift = {rem_ff[DEN_W-1:0], num_ff[DIV_W-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      q_bit     = (rem_shift >= {1'b0, den_ff});
      num_step  = {num_ff[DIV_W-2:0], q_bit};
      div_done  = (cnt_ff == CNT_W'(DIV_W - 1));
      quot      = num_step[ID_W-1:0];
   end

   assign close_pair = req_ch.end_of_sequence || req_ch.end_of_set;
   assign room       = (pairs_ff < PC_W'(MAX_PAIRS));

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      mis_in   = mis_ff;
      total_in = total_ff;
      pairs_in = pairs_ff;
      thr_in   = csr_we ? csr_wdata : thr_ff;
      set_in   = set_ff;
      valid_in = valid_ff;
      diff_in  = diff_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      kind_in  = kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (close_pair) begin
                  pos_in = '0;
                  mis_in = '0;
                  set_in = req_ch.end_of_set;
                  if (room && (pos_upd == '0)) begin
                     // empty pair scores full
                     total_in = total_ff + SUM_W'(FULL_SCORE_Q8);
                     pairs_in = pairs_ff + PC_W'(1);
                     state_in = req_ch.end_of_set ? ST_SETUP : ST_IDLE;
                  end else if (room) begin
                     diff_in  = pos_upd - mis_upd;
                     den_in   = DEN_W'(pos_upd);
                     state_in = ST_MUL;
                  end else begin
                     state_in = req_ch.end_of_set ? ST_SETUP : ST_IDLE;
                  end
               end else begin
                  pos_in = pos_upd;
                  mis_in = mis_upd;
               end
            end
         end
         ST_MUL: begin
            num_in   = DIV_W'(NUM_W'(diff_ff) * NUM_W'(FULL_SCORE_Q8));
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVPAIR;
         end
         ST_DIVPAIR: begin
            num_in = num_step;
            rem_in = q_bit ? rem_sub : rem_shift;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_done) begin
               total_in = total_ff + SUM_W'(quot);
               pairs_in = pairs_ff + PC_W'(1);
               state_in = set_ff ? ST_SETUP : ST_IDLE;
            end
         end
         ST_SETUP: begin
            if (pairs_ff == '0) begin
               res_in   = '0;
               kind_in  = (thr_q8 == '0);
               valid_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               num_in   = DIV_W'(total_ff);
               den_in   = DEN_W'(pairs_ff);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVAVG;
            end
         end
         ST_DIVAVG: begin
            num_in = num_step;
            rem_in = q_bit ? rem_sub : rem_shift;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_done) begin
               res_in   = quot;
               kind_in  = (quot >= thr_q8);
               total_in = '0;
               pairs_in = '0;
               valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         mis_ff   <= '0;
         total_ff <= '0;
         pairs_ff <= '0;
         thr_ff   <= THR_RESET;
         set_ff   <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         mis_ff   <= mis_in;
         total_ff <= total_in;
         pairs_ff <= pairs_in;
         thr_ff   <= thr_in;
         set_ff   <= set_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      kind_ff <= kind_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.identity_q8 = res_ff;
   assign rsp_ch.same_kind   = kind_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.identity_q8 <= FULL_SCORE_Q8))
      else $error("average identity above 100 percent");

   a_kind_match: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.same_kind == (rsp_ch.identity_q8 >= thr_q8)))
      else $error("same_kind disagrees with threshold");

   a_mis_bound: assert property (@(posedge clock) disable iff (reset)
      (mis_ff <= pos_ff) && (pos_ff <= LEN_W'(MAX_SEQ_LEN)))
      else $error("mismatch or position count out of range");

   a_pairs_bound: assert property (@(posedge clock) disable iff (reset)
      (pairs_ff <= PC_W'(MAX_PAIRS)))
      else $error("pair count above limit");

endmodule
